@@ rtl/lslf_pkg.sv @@
// shared types and constants for the least-squares line fit block
// no dependencies; imported by every module of the block but lslf_mul

package lslf_pkg;

    localparam int MAX_PAIRS_DEF = 1024;
    localparam int PC_W          = 11;
    localparam int Q_W           = 32;

    // which quotient the divider works on
    localparam logic DIV_A = 1'b0;
    localparam logic DIV_B = 1'b1;

    typedef struct packed {
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic               last_pair;
    } t_req;

    typedef struct packed {
        logic signed [Q_W-1:0] intercept;
        logic signed [Q_W-1:0] slope;
        logic [PC_W-1:0]       pair_count;
        logic                  singular;
        logic                  overflowed;
    } t_res;

    // product steps of the fit, in issue order
    typedef enum logic [2:0] {
        OP_N_SXX  = 3'd0,
        OP_SX_SX  = 3'd1,
        OP_SY_SXX = 3'd2,
        OP_SX_SXY = 3'd3,
        OP_N_SXY  = 3'd4,
        OP_SX_SY  = 3'd5
    } t_op;

    typedef struct packed {
        logic acc;
        logic publish;
        logic mul_go;
        logic mul_store;
        t_op  op;
        logic div_go;
        logic div_store;
        logic div_sel;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic singular;
    } t_sts;

endpackage

@@ rtl/least_squares_line_fit.sv @@
// Least-squares line fit Y = A + B*X over signed Q8.8 (x, y) pairs. A request is
// taken on a clock edge with start high and busy low; while accumulating, one pair
// is taken every cycle. The request marked last_pair starts the fit and raises busy:
// six products run one after another through a shift-add multiplier of
// OPW = 32 + clog2(MAX_PAIRS+1) bits, then intercept and slope come from a
// one-bit-per-cycle divider over NW = 2*OPW+16 bits; the divisions are skipped
// when the denominator is zero. The result appears on o_res for exactly one cycle
// with o_done high, in the cycle after busy falls, and must be captured then: the
// receiver cannot stall it. Pairs past MAX_PAIRS are dropped and flagged; sums
// clear after each fit. Depends on lslf_pkg, lslf_ctrl, lslf_dp.

module least_squares_line_fit #(
    parameter int MAX_PAIRS = lslf_pkg::MAX_PAIRS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  lslf_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output lslf_pkg::t_res o_res
);

    import lslf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lslf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_req.last_pair),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lslf_dp #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule

@@ rtl/lslf_mul.sv @@
// shift-add multiplier, one multiplier bit per cycle, sign-magnitude result
// depends on nothing outside this file

module lslf_mul #(
    parameter int W = 43
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic                o_done,
    output logic                o_neg,
    output logic [2*W-1:0]      o_mag
);

    localparam int CNT_W = $clog2(W + 1);

    logic [2*W-1:0]   r_acc, n_acc;
    logic [2*W-1:0]   r_mcand, n_mcand;
    logic [W-1:0]     r_mplier, n_mplier;
    logic             r_neg, n_neg;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [W-1:0]     a_mag, b_mag;

    assign a_mag = i_a[W-1] ? W'(-i_a) : W'(i_a);
    assign b_mag = i_b[W-1] ? W'(-i_b) : W'(i_b);

    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        if (i_go) begin
            n_acc    = '0;
            n_mcand  = {{W{1'b0}}, a_mag};
            n_mplier = b_mag;
            n_neg    = i_a[W-1] ^ i_b[W-1];
            n_cnt    = CNT_W'(W);
        end else if (r_cnt != '0) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt - 1'b1;
            n_done   = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_neg    <= n_neg;
    end

    assign o_done = r_done;
    assign o_neg  = r_neg;
    assign o_mag  = r_acc;

endmodule

@@ rtl/lslf_div.sv @@
// restoring divider, one quotient bit per cycle, signed numerator over positive
// denominator, truncated toward zero and saturated to Q_W bits; uses lslf_pkg

module lslf_div #(
    parameter int NW = 102,
    parameter int DW = 86
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic signed [NW-1:0]         i_num,
    input  logic [DW-1:0]                i_den,
    output logic                         o_done,
    output logic signed [lslf_pkg::Q_W-1:0] o_q
);

    import lslf_pkg::*;

    localparam int                CNT_W = $clog2(NW + 1);
    localparam logic [Q_W-1:0]    Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0]    Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    logic [NW-1:0]    r_m, n_m;
    logic [DW-1:0]    r_rem, n_rem;
    logic [Q_W-1:0]   r_q, n_q;
    logic             r_big, n_big;
    logic             r_neg, n_neg;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;

    assign trial = {r_rem, r_m[NW-1]};
    assign diff  = trial - {1'b0, i_den};
    assign ge    = (trial >= {1'b0, i_den});

    always_comb begin
        n_m    = r_m;
        n_rem  = r_rem;
        n_q    = r_q;
        n_big  = r_big;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_go) begin
            n_m   = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            n_neg = i_num[NW-1];
            n_rem = '0;
            n_q   = '0;
            n_big = 1'b0;
            n_cnt = CNT_W'(NW);
        end else if (r_cnt != '0) begin
            n_rem  = ge ? diff[DW-1:0] : trial[DW-1:0];
            n_m    = r_m << 1;
            n_q    = {r_q[Q_W-2:0], ge};
            // any quotient bit above the kept window means saturation
            n_big  = r_big | r_q[Q_W-1];
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m   <= n_m;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_big <= n_big;
        r_neg <= n_neg;
    end

    always_comb begin
        if (r_neg) begin
            o_q = (r_big || (r_q[Q_W-1] && (|r_q[Q_W-2:0]))) ? $signed(Q_MIN)
                                                             : $signed(-r_q);
        end else begin
            o_q = (r_big || r_q[Q_W-1]) ? $signed(Q_MAX) : $signed(r_q);
        end
    end

    assign o_done = r_done;

endmodule

@@ rtl/lslf_dp.sv @@
// datapath: running sums, fit products through a shared multiplier, and the
// two quotients through a shared divider; uses lslf_pkg, lslf_mul, lslf_div

module lslf_dp #(
    parameter int MAX_PAIRS = lslf_pkg::MAX_PAIRS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lslf_pkg::t_req i_req,
    input  lslf_pkg::t_cmd i_cmd,
    output lslf_pkg::t_sts o_sts,
    output logic           o_done,
    output lslf_pkg::t_res o_res
);

    import lslf_pkg::*;

    localparam int CW   = $clog2(MAX_PAIRS + 1);
    localparam int SXW  = 16 + CW;
    localparam int SXYW = 32 + CW;
    localparam int OPW  = SXYW;
    localparam int PW   = 2 * OPW;
    localparam int NW   = PW + 16;

    logic signed [SXW-1:0]  r_sum_x, n_sum_x;
    logic signed [SXW-1:0]  r_sum_y, n_sum_y;
    logic signed [SXYW-1:0] r_sum_xy, n_sum_xy;
    logic signed [SXYW-1:0] r_sum_x2, n_sum_x2;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_dropped, n_dropped;
    logic signed [PW-1:0]   r_den, r_na, r_nb;
    logic signed [Q_W-1:0]  r_qa, r_qb;
    t_res                   r_res;
    logic                   r_done;

    logic signed [31:0]     xy, xx;
    logic signed [OPW-1:0]  n_ext, mul_a, mul_b;
    logic                   mul_done, mul_neg;
    logic [PW-1:0]          mul_mag;
    logic signed [PW-1:0]   prod;
    logic signed [NW-1:0]   div_num;
    logic                   div_done;
    logic signed [Q_W-1:0]  div_q;
    logic                   singular;

    assign xy = $signed(i_req.x_value) * $signed(i_req.y_value);
    assign xx = $signed(i_req.x_value) * $signed(i_req.x_value);

    always_comb begin
        n_sum_x   = r_sum_x;
        n_sum_y   = r_sum_y;
        n_sum_xy  = r_sum_xy;
        n_sum_x2  = r_sum_x2;
        n_count   = r_count;
        n_dropped = r_dropped;
        if (i_cmd.publish) begin
            n_sum_x   = '0;
            n_sum_y   = '0;
            n_sum_xy  = '0;
            n_sum_x2  = '0;
            n_count   = '0;
            n_dropped = 1'b0;
        end else if (i_cmd.acc) begin
            if (r_count >= CW'(MAX_PAIRS)) begin
                n_dropped = 1'b1;
            end else begin
                n_sum_x  = r_sum_x + SXW'(i_req.x_value);
                n_sum_y  = r_sum_y + SXW'(i_req.y_value);
                n_sum_xy = r_sum_xy + SXYW'(xy);
                n_sum_x2 = r_sum_x2 + SXYW'(xx);
                n_count  = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_sum_xy  <= '0;
            r_sum_x2  <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_sum_x   <= n_sum_x;
            r_sum_y   <= n_sum_y;
            r_sum_xy  <= n_sum_xy;
            r_sum_x2  <= n_sum_x2;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_done    <= i_cmd.publish;
        end
    end

    // operand selection for the product steps
    assign n_ext = OPW'($signed({1'b0, r_count}));

    always_comb begin
        unique case (i_cmd.op)
            OP_N_SXX: begin
                mul_a = n_ext;
                mul_b = r_sum_x2;
            end
            OP_SX_SX: begin
                mul_a = OPW'(r_sum_x);
                mul_b = OPW'(r_sum_x);
            end
            OP_SY_SXX: begin
                mul_a = OPW'(r_sum_y);
                mul_b = r_sum_x2;
            end
            OP_SX_SXY: begin
                mul_a = OPW'(r_sum_x);
                mul_b = r_sum_xy;
            end
            OP_N_SXY: begin
                mul_a = n_ext;
                mul_b = r_sum_xy;
            end
            OP_SX_SY: begin
                mul_a = OPW'(r_sum_x);
                mul_b = OPW'(r_sum_y);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lslf_mul #(
        .W (OPW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_neg   (mul_neg),
        .o_mag   (mul_mag)
    );

    assign prod = $signed(mul_mag);

    // first product of each pair loads, second one is subtracted
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_store) begin
            unique case (i_cmd.op)
                OP_N_SXX:  r_den <= mul_neg ? -prod : prod;
                OP_SX_SX:  r_den <= mul_neg ? r_den + prod : r_den - prod;
                OP_SY_SXX: r_na  <= mul_neg ? -prod : prod;
                OP_SX_SXY: r_na  <= mul_neg ? r_na + prod : r_na - prod;
                OP_N_SXY:  r_nb  <= mul_neg ? -prod : prod;
                OP_SX_SY:  r_nb  <= mul_neg ? r_nb + prod : r_nb - prod;
                default:   r_den <= r_den;
            endcase
        end
    end

    assign singular = (r_den == '0);

    // intercept numerator in Q8.8 cubed scale needs 8 more bits, slope 16
    assign div_num = (i_cmd.div_sel == DIV_A) ? $signed({{8{r_na[PW-1]}}, r_na, 8'b0})
                                              : $signed({r_nb, 16'b0});

    lslf_div #(
        .NW (NW),
        .DW (PW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            if (i_cmd.div_sel == DIV_A) begin
                r_qa <= div_q;
            end else begin
                r_qb <= div_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_res.intercept  <= singular ? '0 : r_qa;
            r_res.slope      <= singular ? '0 : r_qb;
            r_res.pair_count <= PC_W'(r_count);
            r_res.singular   <= singular;
            r_res.overflowed <= r_dropped;
        end
    end

    assign o_sts.mul_done = mul_done;
    assign o_sts.div_done = div_done;
    assign o_sts.singular = singular;
    assign o_done         = r_done;
    assign o_res          = r_res;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PAIRS))
        else $error("pair count beyond capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |=> (r_count == '0) && !r_dropped && (r_sum_x2 == '0))
        else $error("sums not cleared after fit");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_go |-> !r_den[PW-1] && (r_den != '0))
        else $error("division started with non-positive denominator");

endmodule

@@ rtl/lslf_ctrl.sv @@
// controller: sequences accumulation, the six fit products, the two divisions
// (skipped when the denominator is zero) and result publication; uses lslf_pkg

module lslf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_last,
    input  lslf_pkg::t_sts i_sts,
    output lslf_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    import lslf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_MUL_GO   = 7'b0000010,
        S_MUL_WAIT = 7'b0000100,
        S_CHECK    = 7'b0001000,
        S_DIV_GO   = 7'b0010000,
        S_DIV_WAIT = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_sel, n_sel;

    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        n_sel           = r_sel;
        o_cmd           = '0;
        o_cmd.op        = r_op;
        o_cmd.div_sel   = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.acc = 1'b1;
                    if (i_last) begin
                        n_op    = OP_N_SXX;
                        n_state = S_MUL_GO;
                    end
                end
            end
            S_MUL_GO: begin
                o_cmd.mul_go = 1'b1;
                n_state      = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_store = 1'b1;
                    if (r_op == OP_SX_SY) begin
                        n_state = S_CHECK;
                    end else begin
                        n_op    = t_op'(r_op + 3'd1);
                        n_state = S_MUL_GO;
                    end
                end
            end
            S_CHECK: begin
                n_sel   = DIV_A;
                n_state = i_sts.singular ? S_DONE : S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_sel == DIV_B) begin
                        n_state = S_DONE;
                    end else begin
                        n_sel   = DIV_B;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_DONE: begin
                o_cmd.publish = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_N_SXX;
            r_sel   <= DIV_A;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_sel   <= n_sel;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ tb/sv/lslf_fit_checker.sv @@
// fit checker for the least-squares line fit block: tracks accepted requests,
// predicts each fit result and compares it with what the block puts out
// depends on lslf_pkg

module lslf_fit_checker #(
    parameter int CAPACITY = lslf_pkg::MAX_PAIRS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  lslf_pkg::t_req i_req,
    input  logic           i_done,
    input  lslf_pkg::t_res i_res,
    output int             o_fail_count,
    output int             o_pending
);

    import lslf_pkg::*;

    localparam logic signed [127:0] Q_MAX = 128'sh7fff_ffff;
    localparam logic signed [127:0] Q_MIN = -128'sh8000_0000;

    longint acc_x, acc_y, acc_xy, acc_xx;
    int     n_pairs;
    bit     lost_pair;
    t_res   fits_due[$];

    function automatic logic [Q_W-1:0] clamp_q16(input logic signed [127:0] q);
        if (q > Q_MAX) begin
            return Q_MAX[Q_W-1:0];
        end
        if (q < Q_MIN) begin
            return Q_MIN[Q_W-1:0];
        end
        return q[Q_W-1:0];
    endfunction

    // exact 128-bit normal equations, quotients truncate toward zero
    function automatic t_res fit_line(input longint sx, input longint sy, input longint sxy,
                                      input longint sxx, input int n, input bit lost);
        logic signed [127:0] wn, wsx, wsy, wsxy, wsxx, den;
        t_res fit;
        wn   = n;
        wsx  = sx;
        wsy  = sy;
        wsxy = sxy;
        wsxx = sxx;
        fit  = '0;
        fit.pair_count = n[PC_W-1:0];
        fit.overflowed = lost;
        den = wn * wsxx - wsx * wsx;
        if (den == 0) begin
            fit.singular = 1'b1;
        end else begin
            fit.intercept = clamp_q16(((wsy * wsxx - wsx * wsxy) <<< 8) / den);
            fit.slope     = clamp_q16(((wn * wsxy - wsx * wsy) <<< 16) / den);
        end
        return fit;
    endfunction

    always @(posedge i_clk) begin
        longint x, y;
        t_res   want;
        if (!i_rst_n) begin
            acc_x = 0;
            acc_y = 0;
            acc_xy = 0;
            acc_xx = 0;
            n_pairs = 0;
            lost_pair = 0;
            fits_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_done) begin
                if (fits_due.size() == 0) begin
                    $error("fit result with none expected");
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = fits_due.pop_front();
                    if (i_res.intercept !== want.intercept) begin
                        $error("intercept: expected %0d, got %0d", want.intercept,
                               i_res.intercept);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_res.slope !== want.slope) begin
                        $error("slope: expected %0d, got %0d", want.slope, i_res.slope);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_res.pair_count !== want.pair_count) begin
                        $error("pair_count: expected %0d, got %0d", want.pair_count,
                               i_res.pair_count);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_res.singular !== want.singular) begin
                        $error("singular: expected %0b, got %0b", want.singular,
                               i_res.singular);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_res.overflowed !== want.overflowed) begin
                        $error("overflowed: expected %0b, got %0b", want.overflowed,
                               i_res.overflowed);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                x = $signed(i_req.x_value);
                y = $signed(i_req.y_value);
                // full set: the pair is dropped, the last one too
                if (n_pairs >= CAPACITY) begin
                    lost_pair = 1;
                end else begin
                    acc_x   = acc_x + x;
                    acc_y   = acc_y + y;
                    acc_xy  = acc_xy + x * y;
                    acc_xx  = acc_xx + x * x;
                    n_pairs = n_pairs + 1;
                end
                if (i_req.last_pair) begin
                    fits_due.push_back(fit_line(acc_x, acc_y, acc_xy, acc_xx, n_pairs,
                                                lost_pair));
                    acc_x = 0;
                    acc_y = 0;
                    acc_xy = 0;
                    acc_xx = 0;
                    n_pairs = 0;
                    lost_pair = 0;
                end
            end
        end
        o_pending = fits_due.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
// top of the least-squares line fit testbench: clock, reset, pair stimulus,
// watchdog and verdict; depends on lslf_pkg, least_squares_line_fit, lslf_fit_checker

module tb_top;

    import lslf_pkg::*;

    localparam int CAPACITY       = MAX_PAIRS_DEF;
    localparam int FIT_CYCLES     = 480;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PAIRS   = 1600;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req req_bus = '0;
    logic busy;
    logic o_done;
    t_res o_res;
    int   fail_count;
    int   fits_pending;
    int   stall_cycles = 0;
    bit   steady = 0;

    always #10 i_clk = ~i_clk;

    least_squares_line_fit #(
        .MAX_PAIRS(CAPACITY)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (req_bus),
        .busy   (busy),
        .o_done (o_done),
        .o_res  (o_res)
    );

    lslf_fit_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (req_bus),
        .i_done      (o_done),
        .i_res       (o_res),
        .o_fail_count(fail_count),
        .o_pending   (fits_pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // busy only moves on a rising edge, so its value at the falling edge decides the request
    task automatic send_pair(input logic [15:0] x, input logic [15:0] y, input logic last);
        t_req r;
        bit   took;
        r.x_value   = x;
        r.y_value   = y;
        r.last_pair = last;
        if (!steady) begin
            while ($urandom_range(0, 99) < 10) begin
                start   <= 1'b0;
                req_bus <= t_req'(33'($urandom));
                @(negedge i_clk);
            end
        end
        start   <= 1'b1;
        req_bus <= r;
        do begin
            took = !busy;
            @(negedge i_clk);
        end while (!took);
    endtask

    function automatic logic [15:0] pick_q88();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3, 4, 5: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_set(input int len, input bit same_x);
        logic [15:0] x0;
        x0 = pick_q88();
        for (int i = 0; i < len; i++) begin
            send_pair(same_x ? x0 : pick_q88(), pick_q88(), i == len - 1);
        end
    endtask

    initial begin
        int sent;
        int len;
        bit big_done;
        sent = 0;
        big_done = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // one pair alone is singular
        send_pair(16'h7fff, 16'h8000, 1'b1);
        // unit x step with full y swing saturates the slope both ways; then x and y at full swing
        send_pair(16'h0000, 16'h8000, 1'b0);
        send_pair(16'h0001, 16'h7fff, 1'b1);
        send_pair(16'h0000, 16'h7fff, 1'b0);
        send_pair(16'h0001, 16'h8000, 1'b1);
        send_pair(16'h8000, 16'h7fff, 1'b0);
        send_pair(16'h7fff, 16'h8000, 1'b0);
        send_pair(16'h0000, 16'h0000, 1'b1);
        // all x equal
        send_pair(16'd100, 16'd5, 1'b0);
        send_pair(16'd100, -16'd7, 1'b0);
        send_pair(16'd100, 16'd300, 1'b1);
        // far from the origin the intercept saturates
        send_pair(16'h7ffe, 16'h8000, 1'b0);
        send_pair(16'h7fff, 16'h7fff, 1'b1);
        send_pair(16'h7ffe, 16'h7fff, 1'b0);
        send_pair(16'h7fff, 16'h8000, 1'b1);
        send_pair(16'h8000, 16'h8000, 1'b0);
        send_pair(16'h8001, 16'h7fff, 1'b1);

        while (sent < RANDOM_PAIRS) begin
            steady = (sent >= 150 && sent < 400);
            if (!big_done && sent >= 450) begin
                // fill one set to capacity or up to three pairs past it
                len = CAPACITY + $urandom_range(0, 3);
                big_done = 1;
            end else if ($urandom_range(0, 9) < 7) begin
                len = $urandom_range(1, 4);
            end else begin
                len = $urandom_range(1, 30);
            end
            send_set(len, $urandom_range(0, 7) == 0);
            sent = sent + len;
        end
        steady = 0;
        start <= 1'b0;

        while (fits_pending != 0) @(negedge i_clk);
        repeat (FIT_CYCLES + 20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
